FILE: hw/rtl/fbpa_pkg.sv
`default_nettype none
package fbpa_pkg;

    localparam int POOL_DEPTH   = 256;
    localparam int ALIGN_BYTES  = 8;    // power of two
    localparam int HEADER_BYTES = 8;

    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int ITEM_W   = 13;
    localparam int STRIDE_W = 14;
    localparam int OFFSET_W = 21;
    localparam int PROD_W   = IDX_W + STRIDE_W;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] LEN_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_BYTES    = 1'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CNT_W-1:0]  RESET_CHUNKS = 9'd256;
    localparam logic [ITEM_W-1:0] RESET_ITEM   = 13'd24;

    typedef enum logic [1:0] {
        STATUS_ALLOC     = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_FREED     = 2'd2,
        STATUS_BAD_FREE  = 2'd3
    } fbpa_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } fbpa_state_t;

    typedef struct packed {
        fbpa_status_t        status;
        logic [IDX_W-1:0]    chunk_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic [CNT_W-1:0]    chunks_outstanding;
    } fbpa_result_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } fbpa_link_req_t;

    // grant limit saturated to the pool depth
    function automatic logic [CNT_W-1:0] fbpa_limit(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] depth;
        depth = CNT_W'(POOL_DEPTH);
        return (v > depth) ? depth : v;
    endfunction

    // item size rounded up to the alignment, plus the header
    function automatic logic [STRIDE_W-1:0] fbpa_stride(input logic [ITEM_W-1:0] v);
        logic [STRIDE_W-1:0] r;
        r = (STRIDE_W'(v) + STRIDE_W'(ALIGN_BYTES - 1)) & ~STRIDE_W'(ALIGN_BYTES - 1);
        return r + STRIDE_W'(HEADER_BYTES);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fbpa_link_ram.sv
`default_nettype none
module fbpa_link_ram (
    input  wire logic                   aclk,
    input  wire fbpa_pkg::fbpa_link_req_t req,
    output logic [fbpa_pkg::IDX_W-1:0]  rd_data
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0] link_mem [POOL_DEPTH];
    logic [IDX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            link_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= link_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/fbpa_ctrl.sv
`default_nettype none
module fbpa_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    input  wire logic                             in_cmd,
    input  wire logic [fbpa_pkg::IDX_W-1:0]       in_free_index,
    output logic                                  in_ready,
    input  wire logic                             out_free,
    output logic                                  res_valid,
    output fbpa_pkg::fbpa_result_t                res,
    input  wire logic                             cfg_wr_en,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [fbpa_pkg::CFG_W-1:0]       cfg_wr_data,
    output fbpa_pkg::fbpa_link_req_t              link_req,
    input  wire logic [fbpa_pkg::IDX_W-1:0]       link_rd_data
);
    import fbpa_pkg::*;

    fbpa_state_t state_reg, state_next;

    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    bump_reg, bump_next;
    logic [CNT_W-1:0]    limit_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic                cmd_reg;
    logic [IDX_W-1:0]    fidx_reg;

    logic             in_fire;
    logic             exec_fire;
    logic             granted;
    logic             link_wr_en;
    logic [IDX_W-1:0] grant_idx;
    logic [PROD_W-1:0] offset_full;

    assign in_fire = in_valid && in_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_EXEC: exec_fire = out_free;
            default: begin
                in_ready  = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // link of the current head is fetched on accept, used in the exec cycle
    assign link_req.rd_en   = in_fire;
    assign link_req.rd_addr = head_reg;
    assign link_req.wr_en   = link_wr_en;
    assign link_req.wr_addr = fidx_reg;
    assign link_req.wr_data = head_reg;

    always_comb begin
        head_next       = head_reg;
        len_next        = len_reg;
        bump_next       = bump_reg;
        granted         = 1'b0;
        grant_idx       = '0;
        link_wr_en      = 1'b0;
        res.status      = STATUS_EXHAUSTED;
        case (cmd_reg)
            CMD_ALLOC: begin
                if (len_reg != '0) begin
                    granted   = 1'b1;
                    grant_idx = head_reg;
                    head_next = link_rd_data;
                    len_next  = len_reg - CNT_W'(1);
                end else if (bump_reg < limit_reg) begin
                    granted   = 1'b1;
                    grant_idx = bump_reg[IDX_W-1:0];
                    bump_next = bump_reg + CNT_W'(1);
                end
                res.status = granted ? STATUS_ALLOC : STATUS_EXHAUSTED;
            end
            default: begin
                if (CNT_W'(fidx_reg) >= bump_reg) begin
                    res.status = STATUS_BAD_FREE;
                end else begin
                    res.status = STATUS_FREED;
                    link_wr_en = exec_fire;
                    head_next  = fidx_reg;
                    if (len_reg != LEN_MAX) len_next = len_reg + CNT_W'(1);
                end
            end
        endcase
        offset_full = PROD_W'(grant_idx) * PROD_W'(stride_reg) + PROD_W'(HEADER_BYTES);
        res.chunk_index        = grant_idx;
        res.byte_offset        = granted ? offset_full[OFFSET_W-1:0] : '0;
        res.chunks_outstanding = (bump_next > len_next) ? (bump_next - len_next) : '0;
    end

    assign res_valid = exec_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            len_reg    <= '0;
            bump_reg   <= '0;
            limit_reg  <= fbpa_limit(RESET_CHUNKS);
            stride_reg <= fbpa_stride(RESET_ITEM);
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                head_reg <= head_next;
                len_reg  <= len_next;
                bump_reg <= bump_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_CHUNKS_IN_USE: limit_reg  <= fbpa_limit(cfg_wr_data[CNT_W-1:0]);
                    CFG_ITEM_BYTES:    stride_reg <= fbpa_stride(cfg_wr_data[ITEM_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg  <= in_cmd;
            fidx_reg <= in_free_index;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_block_pool_allocator_core.sv
// fixed-size block pool allocator, one result transaction per request
// a request is captured with its link memory read; the result is formed in the exec state and then registered
// a new request is taken only once the previous one has left the exec state
// the block stalls in its exec cycle while the result register is still held
// synchronous active-low reset: empty free list, no chunks granted, limit 256, item size 24
`default_nettype none
module fixed_block_pool_allocator_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // free_index
    input  wire logic [0:0]                     s_tuser,   // cmd
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [39:0]                         m_tdata,   // chunk_index, byte_offset,
                                                           // chunks_outstanding, zero pad
    output logic [1:0]                          m_tuser,   // status
    input  wire logic                           cfg_wr_en,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [fbpa_pkg::CFG_W-1:0]     cfg_wr_data
);
    import fbpa_pkg::*;

    fbpa_link_req_t   link_req;
    logic [IDX_W-1:0] link_rd_data;
    fbpa_result_t     res;
    logic             res_valid;
    logic             out_free;

    logic         m_tvalid_reg;
    fbpa_result_t res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    fbpa_link_ram u_link_ram (
        .aclk    (aclk),
        .req     (link_req),
        .rd_data (link_rd_data)
    );

    fbpa_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_cmd        (s_tuser[0]),
        .in_free_index (s_tdata),
        .in_ready      (s_tready),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .link_req      (link_req),
        .link_rd_data  (link_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {2'b00, res_reg.chunks_outstanding, res_reg.byte_offset,
                       res_reg.chunk_index};

`ifndef NO_ASSERTIONS
    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still executing");

    // a result is never dropped: the register is free whenever a new one is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken transaction");

    // granted payload offsets stay aligned to the header/alignment unit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_ALLOC) |-> (m_tdata[10:8] == 3'd0))
        else $error("misaligned payload offset");

    // no grant means zero index and offset, and an outstanding count no larger than the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_ALLOC) |->
            (m_tdata[28:0] == 29'd0 && m_tdata[37:29] <= 9'd256))
        else $error("non-grant result carries chunk data");
`endif

endmodule
`default_nettype wire
